>>> rtl/core/gft_pkg.sv
// ----------------------------------------------------------------------------
// gft_pkg: shared types and constants for the G-code field tokenizer
// Character codes, result kinds, phase codes and the result word layout.
// ----------------------------------------------------------------------------
package gft_pkg;

  // Characters the lexer reacts to
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_Z      = 8'h5A;

  // Result kinds
  localparam logic [1:0] KIND_HEAD = 2'd0;
  localparam logic [1:0] KIND_ARG  = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam int          MASK_W     = 26;
  localparam logic [25:0] MASK_RESET = 26'd59212680;
  localparam int          MANT_W     = 48;

  // Output queue depth; an item may produce two words
  localparam int OUT_DEPTH = 3;

  // Lexer phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_LETTER = 3'b010,
    PH_NUMBER = 3'b100
  } phase_t;

  // One result word
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         letter;
    logic               has_value;
    logic               is_fraction;
    logic [MANT_W-1:0]  mantissa;
    logic [3:0]         frac_digits;
    logic               digit_overflow;
    logic               malformed;
  } result_t;

  // Whitespace: space, tab, LF, VT, FF, CR
  function automatic logic is_blank(logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
           (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

  // Digit, point or minus
  function automatic logic is_num_char(logic [7:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || (c == CH_DOT) || (c == CH_MINUS);
  endfunction

  // Ten to the n, minus one (elaboration only)
  function automatic logic [63:0] pow10_m1(int n);
    logic [63:0] v;
    v = 64'd1;
    for (int i = 0; i < n; i++) begin
      v = v * 64'd10;
    end
    return v - 64'd1;
  endfunction

endpackage

>>> rtl/core/gcode_field_tokenizer.sv
// Each accepted byte's result words are registered in the output queue.
// Throughput: one byte per cycle while the queue has room, lexed in one
// combinational pass between the input handshake and a three-entry output
// queue. An end marker that closes a pending number yields two words,
// drained one per cycle; input stalls only while the queue holds two or more.
// Reset (synchronous, rst high) clears lexer state and queue, mask to default.
// ----------------------------------------------------------------------------
// gcode_field_tokenizer: G-code letter/number field lexer
// Skips comments and whitespace, forms letter-plus-number fields and gives
// each as letter, signed decimal mantissa, fraction digit count and kind.
// ----------------------------------------------------------------------------
module gcode_field_tokenizer
  import gft_pkg::*;
#(
  parameter int MANT_DIGITS = 14
) (
  input  logic              clk,
  input  logic              rst,
  // configuration write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MASK_W-1:0] cfg_data,
  // text input
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        text_byte,
  input  logic              end_of_text,
  // result output
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        kind,
  output logic [7:0]        letter,
  output logic              has_value,
  output logic              is_fraction,
  output logic signed [MANT_W-1:0] mantissa,
  output logic [3:0]        frac_digits,
  output logic              digit_overflow,
  output logic              malformed
);

  localparam logic [63:0] MANT_LIMIT  = pow10_m1(MANT_DIGITS);
  localparam int          ACC_W       = $clog2(MANT_LIMIT + 64'd1);
  localparam int          PW          = ACC_W + 4;
  localparam int          MW          = (ACC_W > MANT_W) ? ACC_W : MANT_W;
  localparam int          FRAC_LIMIT  = (MANT_DIGITS < 15) ? MANT_DIGITS : 15;
  localparam logic [PW-1:0] LIM_P     = PW'(MANT_LIMIT);
  localparam logic [3:0]  FRAC_LIM4   = 4'(FRAC_LIMIT);

  // Number accumulator state
  typedef struct packed {
    logic             neg;
    logic [ACC_W-1:0] acc;
    logic [3:0]       frac;
    logic             point_seen;
    logic             any_point;
    logic             stopped;
    logic             digit_seen;
    logic             ovf;
  } num_t;

  localparam num_t NUM_CLEAR = '0;

  // Fold one number character into the accumulator
  function automatic num_t take_char(num_t s, logic [7:0] c, logic first);
    num_t          r;
    logic [3:0]    d;
    logic [PW-1:0] prod;
    r    = s;
    d    = 4'(c - CH_0);
    prod = (PW'(s.acc) << 3) + (PW'(s.acc) << 1) + PW'(d);
    if (c == CH_DOT) r.any_point = 1'b1;
    if (!s.stopped) begin
      if (c == CH_MINUS) begin
        if (first) r.neg = 1'b1;
        else       r.stopped = 1'b1;
      end else if (c == CH_DOT) begin
        if (s.point_seen) r.stopped = 1'b1;
        else              r.point_seen = 1'b1;
      end else begin
        r.digit_seen = 1'b1;
        if (!s.ovf) begin
          if ((prod > LIM_P) || (s.point_seen && (s.frac >= FRAC_LIM4))) begin
            r.ovf = 1'b1;
          end else begin
            r.acc = prod[ACC_W-1:0];
            if (s.point_seen) r.frac = s.frac + 4'd1;
          end
        end
      end
    end
    return r;
  endfunction

  // Lexer state
  phase_t            phase, phase_next;
  logic              in_comment, in_comment_next;
  logic [7:0]        held_letter, held_letter_next;
  num_t              num, num_next;
  logic              first_field, first_field_next;
  logic [MASK_W-1:0] letter_mask;

  // Output queue
  result_t     q_mem [OUT_DEPTH];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [1:0]  count;

  logic        in_fire, out_fire;
  logic [1:0]  push_n;
  result_t     res0, res1;
  result_t     field_nv, field_v, end_word;
  num_t        num_in, num_taken;
  logic        is_arg;
  logic [7:0]  letter_off;
  logic [MW-1:0] mag_ext, mant_ext;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = (count <= 2'd1);
  assign out_valid = (count != 2'd0);
  assign cfg_ready = 1'b1;

  // Mask register
  always_ff @(posedge clk) begin
    if (rst) begin
      letter_mask <= MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      letter_mask <= cfg_data;
    end
  end

  // Field words built from current state
  always_comb begin
    letter_off = held_letter - CH_A;
    is_arg     = (held_letter >= CH_A) && (held_letter <= CH_Z) &&
                 letter_mask[letter_off[4:0]] && !first_field;
    mag_ext    = MW'(num.acc);
    mant_ext   = num.neg ? (~mag_ext + MW'(1)) : mag_ext;

    field_nv        = '0;
    field_nv.kind   = is_arg ? KIND_ARG : KIND_HEAD;
    field_nv.letter = held_letter;

    field_v                = field_nv;
    field_v.has_value      = 1'b1;
    field_v.is_fraction    = num.any_point;
    field_v.mantissa       = mant_ext[MANT_W-1:0];
    field_v.frac_digits    = num.frac;
    field_v.digit_overflow = num.ovf;
    field_v.malformed      = !num.digit_seen;

    end_word      = '0;
    end_word.kind = KIND_END;
  end

  // Next-state and result selection for one byte
  always_comb begin
    phase_next       = phase;
    in_comment_next  = in_comment;
    held_letter_next = held_letter;
    num_next         = num;
    first_field_next = first_field;
    res0             = end_word;
    res1             = end_word;
    push_n           = 2'd0;

    num_in    = (phase == PH_LETTER) ? NUM_CLEAR : num;
    num_taken = take_char(num_in, text_byte, (phase == PH_LETTER));

    if (in_fire) begin
      if (end_of_text) begin
        // flush pending number, then end marker; back to stream start
        if (phase == PH_NUMBER) begin
          res0   = field_v;
          push_n = 2'd2;
        end else begin
          push_n = 2'd1;
        end
        phase_next       = PH_IDLE;
        in_comment_next  = 1'b0;
        held_letter_next = 8'h00;
        num_next         = NUM_CLEAR;
        first_field_next = 1'b1;
      end else if (in_comment) begin
        if (text_byte == CH_RPAREN) in_comment_next = 1'b0;
      end else if (text_byte == CH_LPAREN) begin
        in_comment_next = 1'b1;
      end else begin
        case (phase)
          PH_IDLE: begin
            if (!is_blank(text_byte)) begin
              held_letter_next = text_byte;
              phase_next       = PH_LETTER;
            end
          end
          PH_LETTER: begin
            if (is_blank(text_byte)) begin
              phase_next = PH_LETTER;
            end else if (is_num_char(text_byte)) begin
              num_next   = num_taken;
              phase_next = PH_NUMBER;
            end else begin
              // letter with no value; this byte is the next letter
              res0             = field_nv;
              push_n           = 2'd1;
              first_field_next = 1'b0;
              num_next         = NUM_CLEAR;
              held_letter_next = text_byte;
            end
          end
          PH_NUMBER: begin
            if (is_num_char(text_byte)) begin
              num_next = num_taken;
            end else begin
              res0             = field_v;
              push_n           = 2'd1;
              first_field_next = 1'b0;
              num_next         = NUM_CLEAR;
              if (is_blank(text_byte)) begin
                phase_next = PH_IDLE;
              end else begin
                held_letter_next = text_byte;
                phase_next       = PH_LETTER;
              end
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Lexer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      in_comment  <= 1'b0;
      held_letter <= 8'h00;
      num         <= NUM_CLEAR;
      first_field <= 1'b1;
    end else begin
      phase       <= phase_next;
      in_comment  <= in_comment_next;
      held_letter <= held_letter_next;
      num         <= num_next;
      first_field <= first_field_next;
    end
  end

  // Queue pointer step, modulo depth
  function automatic logic [1:0] ptr_inc(logic [1:0] p);
    return (p == 2'(OUT_DEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  // Output queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_mem[wr_ptr] <= res0;
    if (push_n == 2'd2) q_mem[ptr_inc(wr_ptr)] <= res1;
  end

  // Output queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 2'd0;
    end else begin
      if (push_n == 2'd1)      wr_ptr <= ptr_inc(wr_ptr);
      else if (push_n == 2'd2) wr_ptr <= ptr_inc(ptr_inc(wr_ptr));
      if (out_fire) rd_ptr <= ptr_inc(rd_ptr);
      count <= count + push_n - {1'b0, out_fire};
    end
  end

  // Head word to ports
  assign kind           = q_mem[rd_ptr].kind;
  assign letter         = q_mem[rd_ptr].letter;
  assign has_value      = q_mem[rd_ptr].has_value;
  assign is_fraction    = q_mem[rd_ptr].is_fraction;
  assign mantissa       = q_mem[rd_ptr].mantissa;
  assign frac_digits    = q_mem[rd_ptr].frac_digits;
  assign digit_overflow = q_mem[rd_ptr].digit_overflow;
  assign malformed      = q_mem[rd_ptr].malformed;

`ifndef SYNTHESIS
  // queue never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(OUT_DEPTH))
    else $error("output queue overfilled");

  // end of text returns the lexer to stream start
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (in_fire && end_of_text) |=> (phase == PH_IDLE) && first_field && !in_comment)
    else $error("lexer not reset after end of text");

  // end while in a number queues both the field and the end marker
  a_end_two_words: assert property (@(posedge clk) disable iff (rst)
    (in_fire && end_of_text && (phase == PH_NUMBER) && !out_fire)
      |=> (count == $past(count) + 2'd2))
    else $error("pending number not flushed with end marker");

  // a word is only queued by an accepted byte
  a_push_needs_fire: assert property (@(posedge clk) disable iff (rst)
    (!in_fire && !out_fire) |=> $stable(count))
    else $error("queue changed with no handshake");
`endif

endmodule
